// ===== src/gnvu_pkg.sv =====
package gnvu_pkg;

  localparam int unsigned NumLanes = 3;

  // Configuration register indexes.
  localparam logic [2:0] CfgTimeStep = 3'd0;
  localparam logic [2:0] CfgGravity  = 3'd1;
  localparam logic [2:0] CfgSizeX    = 3'd2;
  localparam logic [2:0] CfgSizeY    = 3'd3;
  localparam logic [2:0] CfgSizeZ    = 3'd4;
  localparam logic [2:0] CfgWall     = 3'd5;

  // One lane's result after the divider.
  typedef struct packed {
    logic signed [31:0] vel;
    logic               sat;
  } lane_res_t;

endpackage

// ===== src/gnvu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage. Quotient of
// |num| / den truncated toward zero, sign applied at the end, saturated to 32 bits,
// then added to the velocity and saturated again; bypass passes the velocity through. A side payload rides along.
module gnvu_div #(
  parameter int NumW = 48,
  parameter int SideW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [NumW-1:0] in_num,
  input  logic [31:0]           in_den,
  input  logic signed [31:0]    in_vel,
  input  logic                  in_bypass,
  input  logic [SideW-1:0]      in_side,
  output logic                  out_valid,
  output gnvu_pkg::lane_res_t   out_res,
  output logic [SideW-1:0]      out_side
);
  import gnvu_pkg::*;

  localparam int Stages = NumW;

  logic [Stages:0]         vld_r;
  logic [NumW-1:0]         rem_r  [Stages+1];
  logic [NumW-1:0]         quo_r  [Stages+1];
  logic [31:0]             den_r  [Stages+1];
  logic                    neg_r  [Stages+1];
  logic signed [31:0]      vel_r  [Stages+1];
  logic                    byp_r  [Stages+1];
  logic [SideW-1:0]        side_r [Stages+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Stages-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= in_num[NumW-1] ? NumW'(-in_num) : NumW'(in_num);
      den_r[0]  <= in_den;
      neg_r[0]  <= in_num[NumW-1];
      vel_r[0]  <= in_vel;
      byp_r[0]  <= in_bypass;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NumW:0] shifted;
    logic [NumW:0] diff;
    assign shifted = {rem_r[s], quo_r[s][NumW-1]};
    assign diff    = shifted - {{(NumW-31){1'b0}}, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= diff[NumW] ? shifted[NumW-1:0] : diff[NumW-1:0];
        quo_r[s+1]  <= {quo_r[s][NumW-2:0], ~diff[NumW]};
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        vel_r[s+1]  <= vel_r[s];
        byp_r[s+1]  <= byp_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  logic [NumW-1:0]  q;
  logic signed [32:0] dv;
  logic             dv_sat;
  logic signed [32:0] sum;

  always_comb begin
    q = quo_r[Stages];
    dv_sat = 1'b0;
    if (neg_r[Stages]) begin
      if (q > NumW'(33'h80000000)) begin
        dv = -33'sh80000000;
        dv_sat = 1'b1;
      end else begin
        dv = -$signed({1'b0, q[31:0]});
      end
    end else if (q > NumW'(32'h7fffffff)) begin
      dv = 33'sh7fffffff;
      dv_sat = 1'b1;
    end else begin
      dv = $signed({1'b0, q[31:0]});
    end
    sum = 33'(vel_r[Stages]) + dv;
    out_res.sat = 1'b0;
    if (byp_r[Stages]) begin
      out_res.vel = vel_r[Stages];
    end else if (sum > 33'sh7fffffff) begin
      out_res.vel = 32'sh7fffffff;
      out_res.sat = 1'b1;
    end else if (sum < -33'sh80000000) begin
      out_res.vel = 32'sh80000000;
      out_res.sat = 1'b1;
    end else begin
      out_res.vel = sum[31:0];
      out_res.sat = dv_sat;
    end
  end

  assign out_valid = vld_r[Stages];
  assign out_side  = side_r[Stages];

endmodule

// ===== src/gnvu_merge.sv =====
// Wall clamp of all three lanes plus the final output register.
module gnvu_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  gnvu_pkg::lane_res_t lane_x,
  input  gnvu_pkg::lane_res_t lane_y,
  input  gnvu_pkg::lane_res_t lane_z,
  input  logic [7:0]          idx_x,
  input  logic [7:0]          idx_y,
  input  logic [7:0]          idx_z,
  input  logic [8:0]          sz_x,
  input  logic [8:0]          sz_y,
  input  logic [8:0]          sz_z,
  input  logic [4:0]          thick,
  input  logic signed [31:0]  fy,
  input  logic                fy_sat,
  output logic                out_valid,
  output logic signed [31:0]  vx,
  output logic signed [31:0]  vy,
  output logic signed [31:0]  vz,
  output logic signed [31:0]  fy_o,
  output logic                sat_o
);
  import gnvu_pkg::*;

  function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
      input logic [7:0] idx, input logic [8:0] sz, input logic [4:0] t);
    logic signed [31:0] r;
    r = v;
    if ({1'b0, idx} < {4'd0, t} && v < 0) r = '0;
    if (({2'b0, idx} + {5'd0, t}) >= {1'b0, sz} && v > 0) r = '0;
    return r;
  endfunction

  logic vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (en) vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx    <= clamp(lane_x.vel, idx_x, sz_x, thick);
      vy    <= clamp(lane_y.vel, idx_y, sz_y, thick);
      vz    <= clamp(lane_z.vel, idx_z, sz_z, thick);
      fy_o  <= fy;
      sat_o <= lane_x.sat | lane_y.sat | lane_z.sat | fy_sat;
    end
  end

  assign out_valid = vld_r;

endmodule

// ===== src/grid_node_velocity_update.sv =====
// Each word passes through a 48-stage divider on its way from input to output.
// Throughput: one word per cycle unless the output stalls; the three divider lanes set it.
// A stall on a valid output word freezes the whole pipeline; input stall follows it.
// Reset (synchronous, active low) clears pipeline valid bits and loads register defaults.
// Configuration registers are read as each word passes its stage; write them only while idle.
module grid_node_velocity_update #(
  parameter int MAX_DIM = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_node_x,
  input  logic [7:0]         in_node_y,
  input  logic [7:0]         in_node_z,
  input  logic [31:0]        in_node_mass,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_force_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic signed [31:0] out_new_force_y,
  output logic               out_saturated
);
  import gnvu_pkg::*;

  localparam int FracBits = 16;
  localparam int NumW = 48;
  localparam int SideW = 8 * 3 + 32 + 1;

  logic [15:0] ts_r;
  logic [21:0] grav_r;
  logic [8:0]  sx_r, sy_r, sz_r;
  logic [4:0]  wt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= 16'd66;
      grav_r <= 22'(3 << FracBits);
      sx_r   <= 9'd64;
      sy_r   <= 9'd64;
      sz_r   <= 9'd64;
      wt_r   <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgTimeStep: ts_r   <= cfg_data[15:0];
        CfgGravity:  grav_r <= cfg_data;
        CfgSizeX:    sx_r   <= cfg_data[8:0];
        CfgSizeY:    sy_r   <= cfg_data[8:0];
        CfgSizeZ:    sz_r   <= cfg_data[8:0];
        CfgWall:     wt_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  function automatic logic [8:0] cap(input logic [8:0] s);
    return (int'(s) > MAX_DIM) ? 9'(MAX_DIM) : s;
  endfunction

  // The whole pipeline advances together when the output is not held.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: gravity product.
  logic              v1_r;
  logic [53:0]       gm_r;
  logic [7:0]        nx1_r, ny1_r, nz1_r;
  logic [31:0]       m1_r;
  logic signed [31:0] fx1_r, fy1_r, fz1_r, vx1_r, vy1_r, vz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      gm_r <= 54'(grav_r) * 54'(in_node_mass);
      nx1_r <= in_node_x; ny1_r <= in_node_y; nz1_r <= in_node_z;
      m1_r <= in_node_mass;
      fx1_r <= in_force_x; fy1_r <= in_force_y; fz1_r <= in_force_z;
      vx1_r <= in_vel_x; vy1_r <= in_vel_y; vz1_r <= in_vel_z;
    end
  end

  // Stage 2: saturating y force update.
  logic signed [39:0] fy_diff;
  logic signed [31:0] fy_new;
  logic               fy_sat;
  always_comb begin
    fy_diff = 40'(fy1_r) - $signed({2'b0, gm_r[53:FracBits]});
    fy_sat = 1'b0;
    if (m1_r == '0) begin
      fy_new = fy1_r;
    end else if (fy_diff > 40'sh7fffffff) begin
      fy_new = 32'sh7fffffff; fy_sat = 1'b1;
    end else if (fy_diff < -40'sh80000000) begin
      fy_new = 32'sh80000000; fy_sat = 1'b1;
    end else begin
      fy_new = fy_diff[31:0];
    end
  end

  logic              v2_r;
  logic [7:0]        nx2_r, ny2_r, nz2_r;
  logic [31:0]       m2_r;
  logic signed [31:0] fx2_r, fy2_r, fz2_r, vx2_r, vy2_r, vz2_r;
  logic              fs2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx2_r <= nx1_r; ny2_r <= ny1_r; nz2_r <= nz1_r; m2_r <= m1_r;
      fx2_r <= fx1_r; fy2_r <= fy_new; fz2_r <= fz1_r;
      vx2_r <= vx1_r; vy2_r <= vy1_r; vz2_r <= vz1_r; fs2_r <= fy_sat;
    end
  end

  // Stage 3: dt * force numerators.
  logic              v3_r;
  logic signed [NumW-1:0] nmx_r, nmy_r, nmz_r;
  logic [7:0]        nx3_r, ny3_r, nz3_r;
  logic [31:0]       m3_r;
  logic signed [31:0] fy3_r, vx3_r, vy3_r, vz3_r;
  logic              fs3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nmx_r <= NumW'($signed({1'b0, ts_r}) * fx2_r);
      nmy_r <= NumW'($signed({1'b0, ts_r}) * fy2_r);
      nmz_r <= NumW'($signed({1'b0, ts_r}) * fz2_r);
      nx3_r <= nx2_r; ny3_r <= ny2_r; nz3_r <= nz2_r; m3_r <= m2_r;
      fy3_r <= fy2_r; vx3_r <= vx2_r; vy3_r <= vy2_r; vz3_r <= vz2_r;
      fs3_r <= fs2_r;
    end
  end

  // Three divider lanes; lane x carries the side payload.
  logic [SideW-1:0] side_in, side_out;
  logic             dvx, dvy, dvz;
  lane_res_t        rx, ry, rz;
  logic [7:0]       unused_y, unused_z;
  logic             bypass;
  assign bypass  = (m3_r == '0);
  assign side_in = {nx3_r, ny3_r, nz3_r, fy3_r, fs3_r};

  gnvu_div #(.NumW(NumW), .SideW(SideW)) u_div_x (
    .clk, .rst_n, .en, .in_valid(v3_r), .in_num(nmx_r), .in_den(m3_r),
    .in_vel(vx3_r), .in_bypass(bypass), .in_side(side_in),
    .out_valid(dvx), .out_res(rx), .out_side(side_out));
  gnvu_div #(.NumW(NumW), .SideW(8)) u_div_y (
    .clk, .rst_n, .en, .in_valid(v3_r), .in_num(nmy_r), .in_den(m3_r),
    .in_vel(vy3_r), .in_bypass(bypass), .in_side(ny3_r),
    .out_valid(dvy), .out_res(ry), .out_side(unused_y));
  gnvu_div #(.NumW(NumW), .SideW(8)) u_div_z (
    .clk, .rst_n, .en, .in_valid(v3_r), .in_num(nmz_r), .in_den(m3_r),
    .in_vel(vz3_r), .in_bypass(bypass), .in_side(nz3_r),
    .out_valid(dvz), .out_res(rz), .out_side(unused_z));

  gnvu_merge u_merge (
    .clk, .rst_n, .en, .in_valid(dvx),
    .lane_x(rx), .lane_y(ry), .lane_z(rz),
    .idx_x(side_out[56:49]), .idx_y(side_out[48:41]), .idx_z(side_out[40:33]),
    .sz_x(cap(sx_r)), .sz_y(cap(sy_r)), .sz_z(cap(sz_r)), .thick(wt_r),
    .fy(side_out[32:1]), .fy_sat(side_out[0]),
    .out_valid(out_valid), .vx(out_new_vel_x), .vy(out_new_vel_y),
    .vz(out_new_vel_z), .fy_o(out_new_force_y), .sat_o(out_saturated));

`ifndef ASSERT_OFF
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (dvx == dvy) && (dvx == dvz))
    else $error("divider lanes out of step");
  a_lane_side: assert property (@(posedge clk) disable iff (!rst_n)
    dvx |-> (unused_y == side_out[48:41]) && (unused_z == side_out[40:33]))
    else $error("lane payloads disagree");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_vel_x))
    else $error("held output word changed");
`endif

endmodule

// ===== verif/gnvu_checker.sv =====
`timescale 1ns / 1ps
module gnvu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_node_x,
  input  logic [7:0]         in_node_y,
  input  logic [7:0]         in_node_z,
  input  logic [31:0]        in_node_mass,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_force_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_new_vel_x,
  input  logic signed [31:0] out_new_vel_y,
  input  logic signed [31:0] out_new_vel_z,
  input  logic signed [31:0] out_new_force_y,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 pending
);
  import gnvu_pkg::*;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] fy;
    logic               sat;
  } node_result_t;

  node_result_t result_q[$];
  logic [15:0] dt_r;
  logic [21:0] grav_r;
  logic [8:0]  sx_r, sy_r, sz_r;
  logic [4:0]  thick_r;

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v,
                                                inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] integrate(input logic signed [63:0] vel,
      input logic signed [63:0] frc, input logic signed [63:0] mass, inout logic flag);
    logic signed [63:0] num;
    logic signed [63:0] dv;
    num = $signed({48'd0, dt_r}) * frc;
    dv = clip32(num / mass, flag);
    return clip32(vel + dv, flag);
  endfunction

  function automatic logic signed [63:0] clamp_wall(input logic signed [63:0] v,
      input logic [7:0] idx, input logic [8:0] size);
    int sz;
    sz = (size > 256) ? 256 : size;
    if (idx < thick_r && v < 0) v = 0;
    if (int'(idx) + int'(thick_r) >= sz && v > 0) v = 0;
    return v;
  endfunction

  function automatic node_result_t predict_node();
    node_result_t r;
    logic flag;
    logic signed [63:0] vx, vy, vz, fy, m, term;
    flag = 1'b0;
    vx = 64'(in_vel_x);
    vy = 64'(in_vel_y);
    vz = 64'(in_vel_z);
    fy = 64'(in_force_y);
    if (in_node_mass != 0) begin
      m = $signed({32'd0, in_node_mass});
      term = $signed(({42'd0, grav_r} * {32'd0, in_node_mass}) >> 16);
      fy = clip32(fy - term, flag);
      vx = integrate(vx, 64'(in_force_x), m, flag);
      vy = integrate(vy, fy, m, flag);
      vz = integrate(vz, 64'(in_force_z), m, flag);
    end
    r.vx = 32'(clamp_wall(vx, in_node_x, sx_r));
    r.vy = 32'(clamp_wall(vy, in_node_y, sy_r));
    r.vz = 32'(clamp_wall(vz, in_node_z, sz_r));
    r.fy = fy[31:0];
    r.sat = flag;
    return r;
  endfunction

  always @(posedge clk) begin
    node_result_t e;
    if (!rst_n) begin
      dt_r <= 16'd66;
      grav_r <= 22'd196608;
      sx_r <= 9'd64;
      sy_r <= 9'd64;
      sz_r <= 9'd64;
      thick_r <= 5'd4;
      fail_count <= 0;
      result_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgTimeStep: dt_r <= cfg_data[15:0];
          CfgGravity:  grav_r <= cfg_data;
          CfgSizeX:    sx_r <= cfg_data[8:0];
          CfgSizeY:    sy_r <= cfg_data[8:0];
          CfgSizeZ:    sz_r <= cfg_data[8:0];
          CfgWall:     thick_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) result_q.push_back(predict_node());
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word");
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (e.vx !== out_new_vel_x || e.vy !== out_new_vel_y ||
              e.vz !== out_new_vel_z || e.fy !== out_new_force_y ||
              e.sat !== out_saturated) begin
            if (fail_count < 10)
              $display({"word mismatch: exp v=%0d %0d %0d fy=%0d s=%0d",
                        " got v=%0d %0d %0d fy=%0d s=%0d"},
                       e.vx, e.vy, e.vz, e.fy, e.sat, out_new_vel_x, out_new_vel_y,
                       out_new_vel_z, out_new_force_y, out_saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end
endmodule

// ===== verif/tb_grid_node_velocity_update.sv =====
`timescale 1ns / 1ps
module tb_grid_node_velocity_update;
  import gnvu_pkg::*;

  // Register index that no register uses.
  localparam logic [2:0] CfgSpare = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [21:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_node_x = '0, in_node_y = '0, in_node_z = '0;
  logic [31:0] in_node_mass = '0;
  logic signed [31:0] in_force_x = '0, in_force_y = '0, in_force_z = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z, out_new_force_y;
  logic out_saturated;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_node_velocity_update dut (.*);
  gnvu_checker chk (.*);

  // Receiver stall: random, or one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 300;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[21:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // The valid stays high after a word so that the next one can follow at once.
  task automatic send_node(input logic [31:0] x, y, z, m, fx, fy, fz, vx, vy, vz);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_node_x <= x[7:0]; in_node_y <= y[7:0]; in_node_z <= z[7:0];
    in_node_mass <= m;
    in_force_x <= fx; in_force_y <= fy; in_force_z <= fz;
    in_vel_x <= vx; in_vel_y <= vy; in_vel_z <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom_range(3);
      3: return $urandom_range(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n)
      send_node($urandom, $urandom, $urandom, rand_mass(), rand_word(), rand_word(),
                rand_word(), rand_word(), rand_word(), rand_word());
  endtask

  task automatic random_config();
    write_reg(CfgTimeStep, $urandom_range(1) ? $urandom : 32'hffff);
    write_reg(CfgGravity, $urandom_range(1) ? $urandom : 32'h3fffff);
    write_reg(CfgSizeX, $urandom_range(511));
    write_reg(CfgSizeY, $urandom_range(1) ? $urandom_range(260) : 32'd0);
    write_reg(CfgSizeZ, $urandom_range(256) + 1);
    write_reg(CfgWall, $urandom_range(31));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 25;
    recv_idle = 60;
    // Directed words: empty node, extremes, walls at both ends.
    send_node(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 1, -5, 5, -5);
    send_node(255, 255, 255, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_node(3, 60, 4, 1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, -7, 7, -7);
    send_node(63, 59, 10, 32'h10000, 32'h10000, -32'h10000, 0, 100, 100, -100);
    send_node(1, 2, 62, 32'h8000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h80000000);
    drain();
    write_reg(CfgTimeStep, 32'hffff);
    write_reg(CfgGravity, 32'h3fffff);
    write_reg(CfgSizeX, 32'd0);
    write_reg(CfgSizeY, 32'd256);
    write_reg(CfgSizeZ, 32'd511);
    write_reg(CfgWall, 32'd16);
    write_reg(CfgSpare, 32'h3fffff);
    send_node(0, 255, 8, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 9, 9, -9);
    send_node(200, 239, 240, 32'hffffffff, -1, -1, -1, 1, 1, 1);
    send_node(15, 16, 0, 3, 32'h12345678, 32'h80000000, 32'h7fffffff, -1, -1, -1);
    send_random(12);
    drain();
    write_reg(CfgWall, 32'd0);
    write_reg(CfgTimeStep, 32'd0);
    write_reg(CfgGravity, 32'd0);
    write_reg(CfgSizeX, 32'd1);
    send_random(10);
    drain();
    random_config();
    send_random(200);
    drain();
    send_idle = 60;
    recv_idle = 25;
    random_config();
    // Long receiver hold-off while words keep coming, so the input stalls.
    hold_req = 1'b1;
    send_random(200);
    drain();
    send_idle = 0;
    recv_idle = 0;
    random_config();
    send_random(200);
    drain();
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
